>>> design/point_projection_to_screen_unit_macros.svh
// Assertion macros for the point projection unit.
// Used by the top level; expects clk and rst in the scope of the use.
`ifndef POINT_PROJECTION_TO_SCREEN_UNIT_MACROS_SVH
`define POINT_PROJECTION_TO_SCREEN_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define PPTS_ASSERT_ALWAYS(name, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("ppts: invariant violated");
`define PPTS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ppts: sequence violated");
`else
`define PPTS_ASSERT_ALWAYS(name, expr)
`define PPTS_ASSERT_NEXT(name, ante, cons)
`endif
`endif

>>> design/ppts_pkg.sv
// Shared types and constants of the point projection unit.
// No dependencies.
`default_nettype none
package ppts_pkg;

  localparam int COORD_W = 32;
  localparam int VIEW_W  = 32;
  localparam int ROW_W   = 64;
  localparam int QUO_W   = 33;

  typedef enum logic [2:0] {
    REG_ROW0_LEFT,
    REG_ROW0_RIGHT,
    REG_ROW1_LEFT,
    REG_ROW1_RIGHT,
    REG_ROW3_LEFT,
    REG_ROW3_RIGHT,
    REG_VIEWPORT_WIDTH,
    REG_VIEWPORT_HEIGHT
  } ppts_reg_t;

  typedef struct packed {
    logic valid;
    logic vis;
  } ppts_ctl_t;

  typedef struct packed {
    logic               vis;
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
  } ppts_res_t;

endpackage
`default_nettype wire

>>> design/ppts_clip.sv
// Clip-space transform: three matrix rows times the world point, two stages.
// Depends on ppts_pkg.
`default_nettype none
module ppts_clip import ppts_pkg::*; #(
  parameter int FRAC_BITS = 16,
  localparam int CW = 66 - FRAC_BITS
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      en,
  input  wire logic                      in_valid,
  input  wire logic signed [COORD_W-1:0] world_x,
  input  wire logic signed [COORD_W-1:0] world_y,
  input  wire logic signed [COORD_W-1:0] world_z,
  input  wire logic [ROW_W-1:0]          row0_left,
  input  wire logic [ROW_W-1:0]          row0_right,
  input  wire logic [ROW_W-1:0]          row1_left,
  input  wire logic [ROW_W-1:0]          row1_right,
  input  wire logic [ROW_W-1:0]          row3_left,
  input  wire logic [ROW_W-1:0]          row3_right,
  output logic                           out_valid,
  output logic signed [CW-1:0]           cx,
  output logic signed [CW-1:0]           cy,
  output logic signed [CW-1:0]           cw
);

  logic                     prod_valid;
  logic signed [2*COORD_W-1:0] prod [9];
  logic signed [2*COORD_W:0]   sum_x, sum_y, sum_w;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else if (en) begin
      prod_valid <= in_valid;
      out_valid  <= prod_valid;
    end
  end

  // Stage one: nine exact products.
  always_ff @(posedge clk) begin
    if (en) begin
      prod[0] <= $signed(row0_left[63:32])  * world_x;
      prod[1] <= $signed(row0_left[31:0])   * world_y;
      prod[2] <= $signed(row0_right[63:32]) * world_z;
      prod[3] <= $signed(row1_left[63:32])  * world_x;
      prod[4] <= $signed(row1_left[31:0])   * world_y;
      prod[5] <= $signed(row1_right[63:32]) * world_z;
      prod[6] <= $signed(row3_left[63:32])  * world_x;
      prod[7] <= $signed(row3_left[31:0])   * world_y;
      prod[8] <= $signed(row3_right[63:32]) * world_z;
    end
  end

  always_comb begin
    sum_x = (2*COORD_W+1)'(prod[0]) + (2*COORD_W+1)'(prod[1]) + (2*COORD_W+1)'(prod[2]);
    sum_y = (2*COORD_W+1)'(prod[3]) + (2*COORD_W+1)'(prod[4]) + (2*COORD_W+1)'(prod[5]);
    sum_w = (2*COORD_W+1)'(prod[6]) + (2*COORD_W+1)'(prod[7]) + (2*COORD_W+1)'(prod[8]);
  end

  // Stage two: floor to the fraction width, then add the constant column.
  always_ff @(posedge clk) begin
    if (en) begin
      cx <= CW'($signed(sum_x[2*COORD_W:FRAC_BITS])) + CW'($signed(row0_right[31:0]));
      cy <= CW'($signed(sum_y[2*COORD_W:FRAC_BITS])) + CW'($signed(row1_right[31:0]));
      cw <= CW'($signed(sum_w[2*COORD_W:FRAC_BITS])) + CW'($signed(row3_right[31:0]));
    end
  end

endmodule
`default_nettype wire

>>> design/ppts_scale.sv
// Scales one numerator by a viewport size and biases it for rounding.
// Three stages; depends on ppts_pkg.
`default_nettype none
module ppts_scale import ppts_pkg::*; #(
  parameter int FRAC_BITS = 16,
  localparam int NUM_W = 67 - FRAC_BITS,
  localparam int WU_W  = 65 - FRAC_BITS,
  localparam int DEN_W = 66 - FRAC_BITS,
  localparam int N_W   = 100 - FRAC_BITS
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    en,
  input  wire ppts_ctl_t               in_ctl,
  input  wire logic signed [NUM_W-1:0] num,
  input  wire logic [WU_W-1:0]         w,
  input  wire logic [VIEW_W-1:0]       view,
  output ppts_ctl_t                    out_ctl,
  output logic [N_W-1:0]               n,
  output logic [DEN_W-1:0]             den,
  output logic                         neg
);

  ppts_ctl_t                 ctl_b, ctl_c;
  logic                      neg_b, neg_c;
  logic [NUM_W-1:0]          mag_b;
  logic [WU_W-1:0]           w_b, w_c;
  logic [2*VIEW_W-1:0]       lo_c;
  logic [NUM_W-1:0]          hi_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_b   <= '0;
      ctl_c   <= '0;
      out_ctl <= '0;
    end else if (en) begin
      ctl_b   <= in_ctl;
      ctl_c   <= ctl_b;
      out_ctl <= ctl_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Sign and magnitude.
      neg_b <= num[NUM_W-1];
      mag_b <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      w_b   <= w;
      // Two partial products of the magnitude with the viewport size.
      neg_c <= neg_b;
      w_c   <= w_b;
      lo_c  <= mag_b[31:0] * view;
      hi_c  <= NUM_W'(mag_b[NUM_W-1:32] * view);
      // Combine; half the divisor is added, less one for negative values.
      neg   <= neg_c;
      n     <= (N_W'(hi_c) << 32) + N_W'(lo_c) + N_W'(w_c) - N_W'(neg_c);
      den   <= {w_c, 1'b0};
    end
  end

endmodule
`default_nettype wire

>>> design/ppts_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// Depends on ppts_pkg.
`default_nettype none
module ppts_div import ppts_pkg::*; #(
  parameter int FRAC_BITS = 16,
  localparam int DEN_W = 66 - FRAC_BITS,
  localparam int N_W   = 100 - FRAC_BITS
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire ppts_ctl_t        in_ctl,
  input  wire logic [N_W-1:0]   n,
  input  wire logic [DEN_W-1:0] den,
  input  wire logic             neg,
  output ppts_ctl_t             out_ctl,
  output logic [QUO_W-1:0]      q,
  output logic                  ovf,
  output logic                  out_neg
);

  ppts_ctl_t        ctl_q [QUO_W+1];
  logic [DEN_W-1:0] rem_q [QUO_W+1];
  logic [DEN_W-1:0] den_q [QUO_W+1];
  logic [QUO_W-1:0] quo_q [QUO_W+1];
  logic [QUO_W-1:0] nlo_q [QUO_W+1];
  logic             ovf_q [QUO_W+1];
  logic             neg_q [QUO_W+1];
  logic [DEN_W:0]   top_bits;
  logic             too_big;

  // The quotient overflows 33 bits when the upper part already reaches den.
  assign top_bits = n[N_W-1:QUO_W];
  assign too_big  = top_bits >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_q[0] <= '0;
    end else if (en) begin
      ctl_q[0] <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0] <= too_big ? '0 : top_bits[DEN_W-1:0];
      den_q[0] <= den;
      quo_q[0] <= '0;
      nlo_q[0] <= n[QUO_W-1:0];
      ovf_q[0] <= too_big;
      neg_q[0] <= neg;
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    logic [DEN_W:0] trial, diff;
    logic           ge;

    always_comb begin
      trial = {rem_q[k], nlo_q[k][QUO_W-1]};
      diff  = trial - {1'b0, den_q[k]};
      ge    = trial >= {1'b0, den_q[k]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_q[k+1] <= '0;
      end else if (en) begin
        ctl_q[k+1] <= ctl_q[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k+1] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        den_q[k+1] <= den_q[k];
        quo_q[k+1] <= {quo_q[k][QUO_W-2:0], ge};
        nlo_q[k+1] <= {nlo_q[k][QUO_W-2:0], 1'b0};
        ovf_q[k+1] <= ovf_q[k];
        neg_q[k+1] <= neg_q[k];
      end
    end
  end

  assign out_ctl = ctl_q[QUO_W];
  assign q       = quo_q[QUO_W];
  assign ovf     = ovf_q[QUO_W];
  assign out_neg = neg_q[QUO_W];

endmodule
`default_nettype wire

>>> design/point_projection_to_screen_unit.sv
// Top level of the point projection unit: configuration registers, pipeline
// control and output buffer. Depends on ppts_pkg, ppts_clip, ppts_scale,
// ppts_div and point_projection_to_screen_unit_macros.svh.
//
// This unit projects one world point (signed fixed point with FRAC_BITS
// fraction bits) through rows 0, 1 and 3 of a 4x4 view-projection matrix and
// maps it to screen pixels, origin top left. When clip w is at or below
// about 0.0001 the word comes out with visible low and both coordinates zero.
// Results are rounded to nearest with ties upward and saturate to 32 bits.
// A new word is taken in every cycle while the output buffer is not full, and
// one result word leaves per cycle while out_ready is high. Most of the depth
// comes from the 34 register stages of the restoring dividers (one per
// quotient bit plus the overflow check). A two-word output buffer lets the
// pipeline keep accepting while one result waits; the pipeline holds only
// when both entries are taken. Configuration writes take effect at once and
// must only be made while no word is in flight. Writes of zero to a viewport
// size are dropped.
`default_nettype none
`include "point_projection_to_screen_unit_macros.svh"
module point_projection_to_screen_unit import ppts_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic signed [COORD_W-1:0] world_x,
  input  wire logic signed [COORD_W-1:0] world_y,
  input  wire logic signed [COORD_W-1:0] world_z,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic                           visible,
  output logic signed [COORD_W-1:0]      screen_x,
  output logic signed [COORD_W-1:0]      screen_y,
  input  wire logic                      cfg_write,
  input  wire logic [2:0]                cfg_index,
  input  wire logic [ROW_W-1:0]          cfg_data
);

  localparam int CW    = 66 - FRAC_BITS;
  localparam int NUM_W = 67 - FRAC_BITS;
  localparam int WU_W  = 65 - FRAC_BITS;
  localparam int DEN_W = 66 - FRAC_BITS;
  localparam int N_W   = 100 - FRAC_BITS;
  localparam logic [ROW_W-1:0] ONE_FX = ROW_W'(1) << FRAC_BITS;
  localparam logic [ROW_W-1:0] VW_RST = ROW_W'(1170) << FRAC_BITS;
  localparam logic [ROW_W-1:0] VH_RST = ROW_W'(2532) << FRAC_BITS;
  localparam logic signed [CW-1:0] W_THRESH = CW'((ONE_FX + ROW_W'(5000)) / ROW_W'(10000));

  // Configuration registers.
  logic [ROW_W-1:0]  row0_left, row0_right, row1_left, row1_right, row3_left, row3_right;
  logic [VIEW_W-1:0] viewport_width, viewport_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      row0_left       <= ONE_FX << 32;
      row0_right      <= '0;
      row1_left       <= ONE_FX;
      row1_right      <= '0;
      row3_left       <= '0;
      row3_right      <= ONE_FX;
      viewport_width  <= VW_RST[VIEW_W-1:0];
      viewport_height <= VH_RST[VIEW_W-1:0];
    end else if (cfg_write) begin
      unique case (ppts_reg_t'(cfg_index))
        REG_ROW0_LEFT:  row0_left  <= cfg_data;
        REG_ROW0_RIGHT: row0_right <= cfg_data;
        REG_ROW1_LEFT:  row1_left  <= cfg_data;
        REG_ROW1_RIGHT: row1_right <= cfg_data;
        REG_ROW3_LEFT:  row3_left  <= cfg_data;
        REG_ROW3_RIGHT: row3_right <= cfg_data;
        REG_VIEWPORT_WIDTH: begin
          if (cfg_data[VIEW_W-1:0] != '0) viewport_width <= cfg_data[VIEW_W-1:0];
        end
        REG_VIEWPORT_HEIGHT: begin
          if (cfg_data[VIEW_W-1:0] != '0) viewport_height <= cfg_data[VIEW_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // The whole pipeline moves together; it holds only while the output
  // buffer is full, which is known from registered state alone.
  logic [1:0] count;
  logic       en;
  assign en       = count != 2'd2;
  assign in_ready = en;

  // Clip transform, stages one and two.
  logic                 clip_valid;
  logic signed [CW-1:0] cx, cy, cw;

  ppts_clip #(.FRAC_BITS(FRAC_BITS)) u_clip (
    .clk, .rst, .en,
    .in_valid (in_valid),
    .world_x, .world_y, .world_z,
    .row0_left, .row0_right, .row1_left, .row1_right, .row3_left, .row3_right,
    .out_valid (clip_valid),
    .cx, .cy, .cw
  );

  // Stage three: numerators, visibility and the unsigned w.
  ppts_ctl_t               ctl_a;
  logic signed [NUM_W-1:0] num_x, num_y;
  logic [WU_W-1:0]         w_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a <= '0;
    end else if (en) begin
      ctl_a.valid <= clip_valid;
      ctl_a.vis   <= cw > W_THRESH;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_x <= NUM_W'(cw) + NUM_W'(cx);
      num_y <= NUM_W'(cw) - NUM_W'(cy);
      w_a   <= cw[WU_W-1:0];
    end
  end

  // Two lanes, one for each screen axis.
  ppts_ctl_t        sc_x_ctl, sc_y_ctl, dv_x_ctl, dv_y_ctl;
  logic [N_W-1:0]   n_x, n_y;
  logic [DEN_W-1:0] den_x, den_y;
  logic             sneg_x, sneg_y, dneg_x, dneg_y, ovf_x, ovf_y;
  logic [QUO_W-1:0] q_x, q_y;

  ppts_scale #(.FRAC_BITS(FRAC_BITS)) u_scale_x (
    .clk, .rst, .en, .in_ctl (ctl_a), .num (num_x), .w (w_a), .view (viewport_width),
    .out_ctl (sc_x_ctl), .n (n_x), .den (den_x), .neg (sneg_x)
  );

  ppts_scale #(.FRAC_BITS(FRAC_BITS)) u_scale_y (
    .clk, .rst, .en, .in_ctl (ctl_a), .num (num_y), .w (w_a), .view (viewport_height),
    .out_ctl (sc_y_ctl), .n (n_y), .den (den_y), .neg (sneg_y)
  );

  ppts_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk, .rst, .en, .in_ctl (sc_x_ctl), .n (n_x), .den (den_x), .neg (sneg_x),
    .out_ctl (dv_x_ctl), .q (q_x), .ovf (ovf_x), .out_neg (dneg_x)
  );

  ppts_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk, .rst, .en, .in_ctl (sc_y_ctl), .n (n_y), .den (den_y), .neg (sneg_y),
    .out_ctl (dv_y_ctl), .q (q_y), .ovf (ovf_y), .out_neg (dneg_y)
  );

  // Applies the sign and saturates to the signed 32-bit range.
  function automatic logic [COORD_W-1:0] sat_coord(input logic neg, input logic ovf,
                                                   input logic [QUO_W-1:0] q);
    logic [COORD_W-1:0] res;
    if (neg) begin
      if (ovf || q > QUO_W'(33'h0_8000_0000)) res = 32'h8000_0000;
      else res = ~q[COORD_W-1:0] + 32'd1;
    end else begin
      if (ovf || q > QUO_W'(33'h0_7FFF_FFFF)) res = 32'h7FFF_FFFF;
      else res = q[COORD_W-1:0];
    end
    return res;
  endfunction

  ppts_res_t res_in;
  always_comb begin
    res_in.vis = dv_x_ctl.vis;
    res_in.sx  = dv_x_ctl.vis ? sat_coord(dneg_x, ovf_x, q_x) : '0;
    res_in.sy  = dv_x_ctl.vis ? sat_coord(dneg_y, ovf_y, q_y) : '0;
  end

  // Two-word output buffer.
  ppts_res_t  obuf [2];
  logic       wr_ptr, rd_ptr;
  logic       push, pop;
  logic [1:0] count_next;

  assign push = en && dv_x_ctl.valid;
  assign pop  = out_valid && out_ready;

  always_comb begin
    count_next = count;
    if (push && !pop) count_next = count + 2'd1;
    else if (pop && !push) count_next = count - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      count <= count_next;
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
    end
  end

  always_ff @(posedge clk) begin
    if (push) obuf[wr_ptr] <= res_in;
  end

  assign out_valid = count != 2'd0;
  assign visible   = obuf[rd_ptr].vis;
  assign screen_x  = obuf[rd_ptr].sx;
  assign screen_y  = obuf[rd_ptr].sy;

  // Both lanes must carry the same word at the same time.
  `PPTS_ASSERT_ALWAYS(a_lane_align, dv_x_ctl == dv_y_ctl)
  // The buffer is never written while it is full.
  `PPTS_ASSERT_ALWAYS(a_no_overfill, !(push && count == 2'd2))
  // A word that pops leaves room, so the pipeline runs in the next cycle.
  `PPTS_ASSERT_NEXT(a_resume, pop && !push, in_ready)
  // A point that does not project leaves with zero coordinates.
  `PPTS_ASSERT_ALWAYS(a_hidden_zero, !(out_valid && !visible) || (screen_x == '0 && screen_y == '0))

endmodule
`default_nettype wire
